>>> design/lolm_pkg.sv
// layer order list manager package: field widths, command and status codes,
// controller states and the result record
// no dependencies
`timescale 1ns / 1ps

package lolm_pkg;

    // fixed field widths
    localparam int MODE_W   = 3;
    localparam int HANDLE_W = 6;
    localparam int SPRITE_W = 8;
    localparam int POS_W    = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int REF_W    = 7;

    localparam logic [REF_W-1:0] REF_MAX = 7'd127;

    // parameter defaults
    localparam int SLOTS_DEF      = 64;
    localparam int SPRITES_DEF    = 256;
    localparam int COORD_BITS_DEF = 16;

    // log2 of the widest used-bit word scanned per step
    localparam int USED_COL_MAX_W = 4;

    // command codes
    localparam logic [MODE_W-1:0] MODE_PLACE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UP      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DOWN    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TOP     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BOTTOM  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DESTROY = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_USED = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_XREAD,
        ST_XEVAL,
        ST_W1,
        ST_W2,
        ST_W3,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [HANDLE_W-1:0] result_handle;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
        logic                top_valid;
        logic [HANDLE_W-1:0] top_slot;
        logic [HANDLE_W-1:0] bottom_slot;
    } t_result;

endpackage

>>> design/lolm_ram.sv
// simple dual-port memory: one write port, one read port with registered data
// no dependencies
`timescale 1ns / 1ps

module lolm_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/lolm_ctrl.sv
// layer order controller: command sequencer, link / used-bit / reference count
// memories and the stack end pointers
// depends on lolm_pkg and lolm_ram
`timescale 1ns / 1ps

module lolm_ctrl #(
    parameter int SLOTS      = lolm_pkg::SLOTS_DEF,
    parameter int SPRITES    = lolm_pkg::SPRITES_DEF,
    parameter int COORD_BITS = lolm_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [lolm_pkg::MODE_W-1:0]         i_mode,
    input  logic [lolm_pkg::HANDLE_W-1:0]       i_handle,
    input  logic [lolm_pkg::SPRITE_W-1:0]       i_sprite_id,
    input  logic signed [lolm_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [lolm_pkg::POS_W-1:0]   i_pos_y,
    output logic                                o_busy,
    output logic                                o_res_valid,
    output lolm_pkg::t_result                   o_res
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LNK_W  = $clog2(SLOTS + 1);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SPR_W  = (SPRITES > 1) ? $clog2(SPRITES) : 1;
    localparam int COL_W  = (SLOT_W < lolm_pkg::USED_COL_MAX_W) ? SLOT_W
                                                                 : lolm_pkg::USED_COL_MAX_W;
    localparam int UW     = 1 << COL_W;
    localparam int ROW_W  = (SLOT_W > COL_W) ? (SLOT_W - COL_W) : 1;
    localparam int ROWS   = ((SLOTS - 1) >> COL_W) + 1;
    localparam int HX_W   = (SLOT_W > lolm_pkg::HANDLE_W) ? SLOT_W : lolm_pkg::HANDLE_W;
    localparam int SX_W   = (SPR_W > lolm_pkg::SPRITE_W) ? SPR_W : lolm_pkg::SPRITE_W;
    localparam int CLR_LEN = (ROWS > SPRITES) ? ROWS : SPRITES;
    localparam int CLR_W  = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;

    localparam logic [LNK_W-1:0] NONE     = LNK_W'(SLOTS);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'((SLOTS - 1) >> COL_W);
    localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_LEN - 1);

    function automatic logic [COL_W-1:0] first_set(input logic [UW-1:0] v);
        logic [COL_W-1:0] idx;
        idx = '0;
        for (int j = UW - 1; j >= 0; j--) begin
            if (v[j]) begin
                idx = COL_W'(j);
            end
        end
        return idx;
    endfunction

    lolm_pkg::t_state r_state, n_state;

    logic [lolm_pkg::MODE_W-1:0]       r_mode;
    logic [lolm_pkg::SPRITE_W-1:0]     r_sid;
    logic signed [lolm_pkg::POS_W-1:0] r_pos_x;
    logic signed [lolm_pkg::POS_W-1:0] r_pos_y;
    logic                              r_in_range;
    logic [SLOT_W-1:0]                 r_s;
    logic [ROW_W-1:0]                  r_row;
    logic [UW-1:0]                     r_word;
    logic [LNK_W-1:0]                  r_a;
    logic [LNK_W-1:0]                  r_b;
    logic [LNK_W-1:0]                  r_x;
    logic [lolm_pkg::SPRITE_W-1:0]     r_sp;
    logic [LNK_W-1:0]                  r_top;
    logic [LNK_W-1:0]                  r_bot;
    logic [CNT_W-1:0]                  r_count;
    logic [lolm_pkg::STATUS_W-1:0]     r_status;
    logic [lolm_pkg::HANDLE_W-1:0]     r_res;
    logic [CLR_W-1:0]                  r_clr;

    // memory ports
    logic                          la_we, lb_we, used_we, ref_we, spr_we, pos_we;
    logic [SLOT_W-1:0]             la_waddr, lb_waddr, la_raddr, lb_raddr;
    logic [LNK_W-1:0]              la_wdata, lb_wdata, la_rd, lb_rd;
    logic [ROW_W-1:0]              used_waddr;
    logic [UW-1:0]                 used_wdata, used_rd;
    logic [SPR_W-1:0]              ref_addr, ref_waddr;
    logic [lolm_pkg::REF_W-1:0]    ref_wdata, ref_rd;
    logic [lolm_pkg::SPRITE_W-1:0] spr_rd;

    // command decode helpers
    logic [HX_W-1:0]   hx;
    logic              in_range_in;
    logic [UW-1:0]     vmask;
    logic [UW-1:0]     free;
    logic              found;
    logic [SLOT_W-1:0] f_slot;
    logic              live;
    logic [LNK_W-1:0]  s_l;
    logic [LNK_W-1:0]  lo, hi, pre, nxt;
    logic [UW-1:0]     onehot;
    logic [SX_W-1:0]   sx, spx;
    logic              sid_ok, sp_ok;
    logic              clr_rows, clr_refs;

    assign hx          = HX_W'(i_handle);
    assign in_range_in = {1'b0, hx} < (HX_W + 1)'(SLOTS);

    always_comb begin
        for (int j = 0; j < UW; j++) begin
            vmask[j] = {1'b0, r_row, COL_W'(j)} < (ROW_W + COL_W + 1)'(SLOTS);
        end
    end

    assign free   = ~used_rd & vmask;
    assign found  = |free;
    assign f_slot = SLOT_W'({r_row, first_set(free)});
    assign live   = r_in_range && used_rd[r_s[COL_W-1:0]];
    assign s_l    = LNK_W'(r_s);
    assign onehot = UW'(1) << r_s[COL_W-1:0];

    // swap pair: lo sits directly below hi
    always_comb begin
        if (r_mode == lolm_pkg::MODE_UP) begin
            lo  = s_l;
            hi  = r_a;
            pre = r_b;
            nxt = r_x;
        end else begin
            lo  = r_b;
            hi  = s_l;
            pre = r_x;
            nxt = r_a;
        end
    end

    assign sx     = SX_W'(r_sid);
    assign spx    = SX_W'(r_sp);
    assign sid_ok = {1'b0, sx} < (SX_W + 1)'(SPRITES);
    assign sp_ok  = {1'b0, spx} < (SX_W + 1)'(SPRITES);

    assign clr_rows = {1'b0, r_clr} < (CLR_W + 1)'(ROWS);
    assign clr_refs = {1'b0, r_clr} < (CLR_W + 1)'(SPRITES);

    assign la_raddr = (r_state == lolm_pkg::ST_XREAD && r_mode == lolm_pkg::MODE_UP)
                      ? SLOT_W'(r_a) : r_s;
    assign lb_raddr = (r_state == lolm_pkg::ST_XREAD && r_mode == lolm_pkg::MODE_DOWN)
                      ? SLOT_W'(r_b) : r_s;
    assign ref_addr = (r_mode == lolm_pkg::MODE_PLACE) ? SPR_W'(sx) : SPR_W'(spx);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lolm_pkg::ST_CLEAR: begin
                if (r_clr == CLR_LAST) n_state = lolm_pkg::ST_IDLE;
            end
            lolm_pkg::ST_IDLE: begin
                if (i_start) n_state = lolm_pkg::ST_READ;
            end
            lolm_pkg::ST_DONE: begin
                n_state = i_start ? lolm_pkg::ST_READ : lolm_pkg::ST_IDLE;
            end
            lolm_pkg::ST_READ: n_state = lolm_pkg::ST_EVAL;
            lolm_pkg::ST_EVAL: begin
                case (r_mode) inside
                    lolm_pkg::MODE_PLACE: begin
                        if (found) n_state = lolm_pkg::ST_W1;
                        else if (r_row == LAST_ROW) n_state = lolm_pkg::ST_DONE;
                        else n_state = lolm_pkg::ST_READ;
                    end
                    lolm_pkg::MODE_UP: begin
                        n_state = (!live || la_rd == NONE) ? lolm_pkg::ST_DONE
                                                           : lolm_pkg::ST_XREAD;
                    end
                    lolm_pkg::MODE_DOWN: begin
                        n_state = (!live || lb_rd == NONE) ? lolm_pkg::ST_DONE
                                                           : lolm_pkg::ST_XREAD;
                    end
                    lolm_pkg::MODE_TOP: begin
                        n_state = (!live || r_top == s_l) ? lolm_pkg::ST_DONE
                                                          : lolm_pkg::ST_W1;
                    end
                    lolm_pkg::MODE_BOTTOM: begin
                        n_state = (!live || r_bot == s_l) ? lolm_pkg::ST_DONE
                                                          : lolm_pkg::ST_W1;
                    end
                    lolm_pkg::MODE_DESTROY: begin
                        n_state = live ? lolm_pkg::ST_W1 : lolm_pkg::ST_DONE;
                    end
                    default: n_state = lolm_pkg::ST_DONE;
                endcase
            end
            lolm_pkg::ST_XREAD: n_state = lolm_pkg::ST_XEVAL;
            lolm_pkg::ST_XEVAL: n_state = lolm_pkg::ST_W1;
            lolm_pkg::ST_W1:    n_state = lolm_pkg::ST_W2;
            lolm_pkg::ST_W2: begin
                n_state = (r_mode == lolm_pkg::MODE_PLACE || r_mode == lolm_pkg::MODE_DESTROY)
                          ? lolm_pkg::ST_DONE : lolm_pkg::ST_W3;
            end
            lolm_pkg::ST_W3:    n_state = lolm_pkg::ST_DONE;
            default:            n_state = lolm_pkg::ST_IDLE;
        endcase
    end

    // memory write controls
    always_comb begin
        la_we      = 1'b0;
        la_waddr   = r_s;
        la_wdata   = NONE;
        lb_we      = 1'b0;
        lb_waddr   = r_s;
        lb_wdata   = NONE;
        used_we    = 1'b0;
        used_waddr = r_row;
        used_wdata = r_word;
        ref_we     = 1'b0;
        ref_waddr  = ref_addr;
        ref_wdata  = ref_rd;
        spr_we     = 1'b0;
        pos_we     = 1'b0;
        unique case (r_state)
            lolm_pkg::ST_CLEAR: begin
                used_we    = clr_rows;
                used_waddr = ROW_W'(r_clr);
                used_wdata = '0;
                ref_we     = clr_refs;
                ref_waddr  = SPR_W'(r_clr);
                ref_wdata  = '0;
            end
            lolm_pkg::ST_W1: begin
                case (r_mode) inside
                    lolm_pkg::MODE_PLACE: begin
                        la_we      = 1'b1;
                        lb_we      = 1'b1;
                        lb_wdata   = r_top;
                        used_we    = 1'b1;
                        used_wdata = r_word | onehot;
                        spr_we     = 1'b1;
                        pos_we     = 1'b1;
                    end
                    lolm_pkg::MODE_UP, lolm_pkg::MODE_DOWN: begin
                        la_we    = pre != NONE;
                        la_waddr = SLOT_W'(pre);
                        la_wdata = hi;
                        lb_we    = nxt != NONE;
                        lb_waddr = SLOT_W'(nxt);
                        lb_wdata = lo;
                    end
                    lolm_pkg::MODE_TOP, lolm_pkg::MODE_BOTTOM, lolm_pkg::MODE_DESTROY: begin
                        // unlink from both neighbours
                        la_we    = r_b != NONE;
                        la_waddr = SLOT_W'(r_b);
                        la_wdata = r_a;
                        lb_we    = r_a != NONE;
                        lb_waddr = SLOT_W'(r_a);
                        lb_wdata = r_b;
                        if (r_mode == lolm_pkg::MODE_DESTROY) begin
                            used_we    = 1'b1;
                            used_wdata = r_word & ~onehot;
                        end
                    end
                    default: ;
                endcase
            end
            lolm_pkg::ST_W2: begin
                case (r_mode) inside
                    lolm_pkg::MODE_PLACE: begin
                        la_we     = r_top != NONE;
                        la_waddr  = SLOT_W'(r_top);
                        la_wdata  = s_l;
                        ref_we    = sid_ok && (ref_rd < lolm_pkg::REF_MAX);
                        ref_wdata = ref_rd + 1'b1;
                    end
                    lolm_pkg::MODE_UP, lolm_pkg::MODE_DOWN: begin
                        la_we    = 1'b1;
                        la_waddr = SLOT_W'(hi);
                        la_wdata = lo;
                        lb_we    = 1'b1;
                        lb_waddr = SLOT_W'(hi);
                        lb_wdata = pre;
                    end
                    lolm_pkg::MODE_TOP: begin
                        la_we    = 1'b1;
                        lb_we    = 1'b1;
                        lb_wdata = r_top;
                    end
                    lolm_pkg::MODE_BOTTOM: begin
                        la_we    = 1'b1;
                        la_wdata = r_bot;
                        lb_we    = 1'b1;
                    end
                    lolm_pkg::MODE_DESTROY: begin
                        ref_we    = sp_ok && (ref_rd != '0);
                        ref_wdata = ref_rd - 1'b1;
                    end
                    default: ;
                endcase
            end
            lolm_pkg::ST_W3: begin
                case (r_mode) inside
                    lolm_pkg::MODE_UP, lolm_pkg::MODE_DOWN: begin
                        la_we    = 1'b1;
                        la_waddr = SLOT_W'(lo);
                        la_wdata = nxt;
                        lb_we    = 1'b1;
                        lb_waddr = SLOT_W'(lo);
                        lb_wdata = hi;
                    end
                    lolm_pkg::MODE_TOP: begin
                        la_we    = 1'b1;
                        la_waddr = SLOT_W'(r_top);
                        la_wdata = s_l;
                    end
                    lolm_pkg::MODE_BOTTOM: begin
                        lb_we    = 1'b1;
                        lb_waddr = SLOT_W'(r_bot);
                        lb_wdata = s_l;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // datapath and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lolm_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_top   <= NONE;
            r_bot   <= NONE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                lolm_pkg::ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                end
                lolm_pkg::ST_IDLE, lolm_pkg::ST_DONE: begin
                    if (i_start) begin
                        r_mode     <= i_mode;
                        r_sid      <= i_sprite_id;
                        r_pos_x    <= i_pos_x;
                        r_pos_y    <= i_pos_y;
                        r_in_range <= in_range_in;
                        r_s        <= SLOT_W'(hx);
                        r_row      <= (i_mode == lolm_pkg::MODE_PLACE) ? '0
                                                                       : ROW_W'(hx >> COL_W);
                        r_res      <= i_handle;
                        r_status   <= lolm_pkg::STAT_OK;
                    end
                end
                lolm_pkg::ST_EVAL: begin
                    r_word <= used_rd;
                    r_a    <= la_rd;
                    r_b    <= lb_rd;
                    r_sp   <= spr_rd;
                    case (r_mode) inside
                        lolm_pkg::MODE_PLACE: begin
                            if (found) begin
                                r_s   <= f_slot;
                                r_res <= lolm_pkg::HANDLE_W'(f_slot);
                            end else if (r_row == LAST_ROW) begin
                                r_status <= lolm_pkg::STAT_FULL;
                                r_res    <= '0;
                            end else begin
                                r_row <= r_row + 1'b1;
                            end
                        end
                        lolm_pkg::MODE_UP, lolm_pkg::MODE_DOWN, lolm_pkg::MODE_TOP,
                        lolm_pkg::MODE_BOTTOM, lolm_pkg::MODE_DESTROY: begin
                            if (!live) r_status <= lolm_pkg::STAT_NOT_USED;
                        end
                        default: ;
                    endcase
                end
                lolm_pkg::ST_XEVAL: begin
                    r_x <= (r_mode == lolm_pkg::MODE_UP) ? la_rd : lb_rd;
                end
                lolm_pkg::ST_W1: begin
                    if (r_mode == lolm_pkg::MODE_DESTROY) begin
                        if (r_b == NONE) r_bot <= r_a;
                        if (r_a == NONE) r_top <= r_b;
                        if (r_count != '0) r_count <= r_count - 1'b1;
                    end
                end
                lolm_pkg::ST_W2: begin
                    if (r_mode == lolm_pkg::MODE_PLACE) begin
                        if (r_top == NONE) r_bot <= s_l;
                        r_top   <= s_l;
                        r_count <= r_count + 1'b1;
                    end
                end
                lolm_pkg::ST_W3: begin
                    case (r_mode) inside
                        lolm_pkg::MODE_UP, lolm_pkg::MODE_DOWN: begin
                            if (pre == NONE) r_bot <= hi;
                            if (nxt == NONE) r_top <= lo;
                        end
                        lolm_pkg::MODE_TOP: begin
                            if (r_b == NONE) r_bot <= r_a;
                            r_top <= s_l;
                        end
                        lolm_pkg::MODE_BOTTOM: begin
                            if (r_a == NONE) r_top <= r_b;
                            r_bot <= s_l;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    lolm_ram #(.ADDR_W(SLOT_W), .DATA_W(LNK_W)) u_above (
        .i_clk     (i_clk),
        .i_we      (la_we),
        .i_wr_addr (la_waddr),
        .i_wr_data (la_wdata),
        .i_rd_addr (la_raddr),
        .o_rd_data (la_rd)
    );

    lolm_ram #(.ADDR_W(SLOT_W), .DATA_W(LNK_W)) u_below (
        .i_clk     (i_clk),
        .i_we      (lb_we),
        .i_wr_addr (lb_waddr),
        .i_wr_data (lb_wdata),
        .i_rd_addr (lb_raddr),
        .o_rd_data (lb_rd)
    );

    lolm_ram #(.ADDR_W(ROW_W), .DATA_W(UW)) u_used (
        .i_clk     (i_clk),
        .i_we      (used_we),
        .i_wr_addr (used_waddr),
        .i_wr_data (used_wdata),
        .i_rd_addr (r_row),
        .o_rd_data (used_rd)
    );

    lolm_ram #(.ADDR_W(SPR_W), .DATA_W(lolm_pkg::REF_W)) u_refs (
        .i_clk     (i_clk),
        .i_we      (ref_we),
        .i_wr_addr (ref_waddr),
        .i_wr_data (ref_wdata),
        .i_rd_addr (ref_addr),
        .o_rd_data (ref_rd)
    );

    lolm_ram #(.ADDR_W(SLOT_W), .DATA_W(lolm_pkg::SPRITE_W)) u_sprite (
        .i_clk     (i_clk),
        .i_we      (spr_we),
        .i_wr_addr (r_s),
        .i_wr_data (r_sid),
        .i_rd_addr (r_s),
        .o_rd_data (spr_rd)
    );

    // placement origins, kept for the slot but not reported
    lolm_ram #(.ADDR_W(SLOT_W), .DATA_W(2 * COORD_BITS)) u_pos (
        .i_clk     (i_clk),
        .i_we      (pos_we),
        .i_wr_addr (r_s),
        .i_wr_data ({COORD_BITS'(r_pos_x), COORD_BITS'(r_pos_y)}),
        .i_rd_addr (r_s),
        .o_rd_data ()
    );

    assign o_busy      = !(r_state == lolm_pkg::ST_IDLE || r_state == lolm_pkg::ST_DONE);
    assign o_res_valid = r_state == lolm_pkg::ST_DONE;

    always_comb begin
        o_res.result_handle = r_res;
        o_res.status        = r_status;
        o_res.entry_count   = lolm_pkg::COUNT_W'(r_count);
        o_res.top_valid     = r_top != NONE;
        o_res.top_slot      = (r_top != NONE) ? lolm_pkg::HANDLE_W'(r_top) : '0;
        o_res.bottom_slot   = (r_bot != NONE) ? lolm_pkg::HANDLE_W'(r_bot) : '0;
    end

    // both stack ends are empty together or not at all
    a_ends_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_top == NONE) == (r_bot == NONE))
        else $error("stack end pointers disagree on emptiness");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOTS))
        else $error("placement count above slot count");

    a_done_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lolm_pkg::ST_DONE) |-> ((r_top != NONE) == (r_count != '0)))
        else $error("top pointer inconsistent with placement count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lolm_pkg::ST_DONE && r_status == lolm_pkg::STAT_FULL)
        |-> (r_count == CNT_W'(SLOTS)))
        else $error("table full reported with free slots");

    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == lolm_pkg::ST_READ))
        else $error("accepted transaction did not start a table read");

endmodule

>>> design/layer_order_list_manager_top.sv
// layer order list manager top level: command port, controller and the
// registered result port
// depends on lolm_pkg, lolm_ctrl
// path from accept to o_done: read and evaluate states (repeated per further 16-slot used-bit
// word scanned by place), a second read and evaluate for up/down, write states W1 and W2 for
// place and destroy and W1 to W3 for up/down/top/bottom, the done state, then the result
// register; a rejected or no-op command skips the write states
// start is taken again in the cycle before the result strobe; results cannot be stalled
// reset: synchronous; busy stays high during a clearing pass over used bits and counts
`timescale 1ns / 1ps

module layer_order_list_manager_top #(
    parameter int SLOTS      = lolm_pkg::SLOTS_DEF,
    parameter int SPRITES    = lolm_pkg::SPRITES_DEF,
    parameter int COORD_BITS = lolm_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [lolm_pkg::MODE_W-1:0]       i_mode,
    input  logic [lolm_pkg::HANDLE_W-1:0]     i_handle,
    input  logic [lolm_pkg::SPRITE_W-1:0]     i_sprite_id,
    input  logic signed [lolm_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [lolm_pkg::POS_W-1:0] i_pos_y,
    output logic                              o_done,
    output logic [lolm_pkg::HANDLE_W-1:0]     o_result_handle,
    output logic [lolm_pkg::STATUS_W-1:0]     o_status,
    output logic [lolm_pkg::COUNT_W-1:0]      o_entry_count,
    output logic                              o_top_valid,
    output logic [lolm_pkg::HANDLE_W-1:0]     o_top_slot,
    output logic [lolm_pkg::HANDLE_W-1:0]     o_bottom_slot
);

    logic              res_valid;
    lolm_pkg::t_result res;
    logic              r_done;
    lolm_pkg::t_result r_out;

    lolm_ctrl #(
        .SLOTS      (SLOTS),
        .SPRITES    (SPRITES),
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_mode      (i_mode),
        .i_handle    (i_handle),
        .i_sprite_id (i_sprite_id),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register, one strobe per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_done          = r_done;
    assign o_result_handle = r_out.result_handle;
    assign o_status        = r_out.status;
    assign o_entry_count   = r_out.entry_count;
    assign o_top_valid     = r_out.top_valid;
    assign o_top_slot      = r_out.top_slot;
    assign o_bottom_slot   = r_out.bottom_slot;

endmodule

>>> tb/lolm_stack_checker.sv
// checker for the layer order list manager: keeps its own copy of the stacking
// list, predicts each result and compares it with the result port
// depends on lolm_pkg
`timescale 1ns / 1ps

module lolm_stack_checker
    import lolm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic                o_done,
    input  logic [HANDLE_W-1:0] o_result_handle,
    input  logic [STATUS_W-1:0] o_status,
    input  logic [COUNT_W-1:0]  o_entry_count,
    input  logic                o_top_valid,
    input  logic [HANDLE_W-1:0] o_top_slot,
    input  logic [HANDLE_W-1:0] o_bottom_slot,
    output int                  fail_count,
    output int                  pending,
    output logic [63:0]         live_map,
    output int                  ok_count,
    output int                  full_count,
    output int                  free_count,
    output int                  peak_count
);

    localparam int NSLOT = 64;
    localparam logic [6:0] NO_LINK = 7'd64;

    // shadow of the stacking list; positions and reference counts never reach
    // the result port, so only the list itself is kept
    logic [NSLOT-1:0] used_bits;
    logic [6:0]       link_up [NSLOT];
    logic [6:0]       link_down [NSLOT];
    logic [6:0]       stack_top;
    logic [6:0]       stack_bottom;
    int unsigned      n_used;

    t_result expected_results [$];

    initial begin
        used_bits    = '0;
        stack_top    = NO_LINK;
        stack_bottom = NO_LINK;
        n_used       = 0;
        fail_count   = 0;
        pending      = 0;
        live_map     = '0;
        ok_count     = 0;
        full_count   = 0;
        free_count   = 0;
        peak_count   = 0;
    end

    function automatic void unlink(logic [6:0] s);
        logic [6:0] dn;
        logic [6:0] up;
        dn = link_down[s[5:0]];
        up = link_up[s[5:0]];
        if (!dn[6]) link_up[dn[5:0]] = up; else stack_bottom = up;
        if (!up[6]) link_down[up[5:0]] = dn; else stack_top = dn;
        link_up[s[5:0]]   = NO_LINK;
        link_down[s[5:0]] = NO_LINK;
    endfunction

    function automatic void link_at_top(logic [6:0] s);
        link_down[s[5:0]] = stack_top;
        link_up[s[5:0]]   = NO_LINK;
        if (!stack_top[6]) link_up[stack_top[5:0]] = s; else stack_bottom = s;
        stack_top = s;
    endfunction

    // exchange s with its neighbour above, if it has one
    function automatic void swap_up(logic [6:0] s);
        logic [6:0] q;
        logic [6:0] pre;
        logic [6:0] nxt;
        q = link_up[s[5:0]];
        if (q[6]) return;
        pre = link_down[s[5:0]];
        nxt = link_up[q[5:0]];
        if (!pre[6]) link_up[pre[5:0]] = q; else stack_bottom = q;
        link_down[q[5:0]] = pre;
        link_up[q[5:0]]   = s;
        link_down[s[5:0]] = q;
        link_up[s[5:0]]   = nxt;
        if (!nxt[6]) link_down[nxt[5:0]] = s; else stack_top = s;
    endfunction

    function automatic t_result predict_command(logic [MODE_W-1:0] mode,
                                                logic [HANDLE_W-1:0] h);
        t_result    r;
        logic [6:0] s;
        logic [6:0] dn;
        int         free_slot;
        r.result_handle = h;
        r.status        = STAT_OK;
        s               = {1'b0, h};
        case (mode)
            MODE_PLACE: begin
                free_slot = -1;
                for (int i = NSLOT - 1; i >= 0; i--) begin
                    if (!used_bits[i]) free_slot = i;
                end
                if (free_slot < 0) begin
                    r.status        = STAT_FULL;
                    r.result_handle = '0;
                end else begin
                    used_bits[free_slot] = 1'b1;
                    link_at_top(7'(free_slot));
                    n_used++;
                    r.result_handle = HANDLE_W'(free_slot);
                end
            end
            MODE_UP, MODE_DOWN, MODE_TOP, MODE_BOTTOM, MODE_DESTROY: begin
                if (!used_bits[h]) begin
                    r.status = STAT_NOT_USED;
                end else begin
                    case (mode)
                        MODE_UP: swap_up(s);
                        MODE_DOWN: begin
                            dn = link_down[h];
                            if (!dn[6]) swap_up(dn);
                        end
                        MODE_TOP: begin
                            if (stack_top != s) begin
                                unlink(s);
                                link_at_top(s);
                            end
                        end
                        MODE_BOTTOM: begin
                            if (stack_bottom != s) begin
                                unlink(s);
                                link_up[h]   = stack_bottom;
                                link_down[h] = NO_LINK;
                                if (!stack_bottom[6]) link_down[stack_bottom[5:0]] = s;
                                else stack_top = s;
                                stack_bottom = s;
                            end
                        end
                        default: begin
                            unlink(s);
                            used_bits[h] = 1'b0;
                            if (n_used > 0) n_used--;
                        end
                    endcase
                end
            end
            default: ;
        endcase
        r.entry_count = COUNT_W'(n_used);
        r.top_valid   = !stack_top[6];
        r.top_slot    = stack_top[6] ? '0 : stack_top[5:0];
        r.bottom_slot = stack_bottom[6] ? '0 : stack_bottom[5:0];
        return r;
    endfunction

    function automatic int field_diff(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", fname, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            // a result strobe always belongs to a transaction taken earlier
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    $error("result strobe with no command outstanding");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    fail_count += field_diff("result_handle", 32'(want.result_handle),
                                             32'(o_result_handle));
                    fail_count += field_diff("status", 32'(want.status), 32'(o_status));
                    fail_count += field_diff("entry_count", 32'(want.entry_count),
                                             32'(o_entry_count));
                    fail_count += field_diff("top_valid", 32'(want.top_valid),
                                             32'(o_top_valid));
                    fail_count += field_diff("top_slot", 32'(want.top_slot),
                                             32'(o_top_slot));
                    fail_count += field_diff("bottom_slot", 32'(want.bottom_slot),
                                             32'(o_bottom_slot));
                    case (want.status)
                        STAT_OK:   ok_count++;
                        STAT_FULL: full_count++;
                        default:   free_count++;
                    endcase
                    if (int'(want.entry_count) > peak_count) begin
                        peak_count = int'(want.entry_count);
                    end
                end
            end
            if (start && !busy) expected_results.push_back(predict_command(i_mode, i_handle));
        end
        pending  <= expected_results.size();
        live_map <= used_bits;
    end

endmodule

>>> tb/tb_layer_order_list_manager_top.sv
// testbench top for the layer order list manager: clock, reset, directed and
// random command stimulus under three pacing phases, and the verdict
// depends on lolm_pkg, layer_order_list_manager_top, lolm_stack_checker
`timescale 1ns / 1ps

module tb_layer_order_list_manager_top;

    import lolm_pkg::*;

    // modes the block does not define; they must leave everything untouched
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

    localparam int TARGET_CMDS   = 1600;
    localparam int DIRECTED_CMDS = 26;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_LIMIT   = 4000;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [MODE_W-1:0]   i_mode = '0;
    logic [HANDLE_W-1:0] i_handle = '0;
    logic [SPRITE_W-1:0] i_sprite_id = '0;
    logic signed [POS_W-1:0] i_pos_x = '0;
    logic signed [POS_W-1:0] i_pos_y = '0;
    logic                o_done;
    logic [HANDLE_W-1:0] o_result_handle;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_entry_count;
    logic                o_top_valid;
    logic [HANDLE_W-1:0] o_top_slot;
    logic [HANDLE_W-1:0] o_bottom_slot;

    int          fail_count;
    int          pending;
    logic [63:0] live_map;
    int          ok_count;
    int          full_count;
    int          free_count;
    int          peak_count;

    int          n_sent = 0;
    int unsigned idle_pct = 0;

    layer_order_list_manager_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_handle       (i_handle),
        .i_sprite_id    (i_sprite_id),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .o_done         (o_done),
        .o_result_handle(o_result_handle),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count),
        .o_top_valid    (o_top_valid),
        .o_top_slot     (o_top_slot),
        .o_bottom_slot  (o_bottom_slot)
    );

    lolm_stack_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_handle       (i_handle),
        .o_done         (o_done),
        .o_result_handle(o_result_handle),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count),
        .o_top_valid    (o_top_valid),
        .o_top_slot     (o_top_slot),
        .o_bottom_slot  (o_bottom_slot),
        .fail_count     (fail_count),
        .pending        (pending),
        .live_map       (live_map),
        .ok_count       (ok_count),
        .full_count     (full_count),
        .free_count     (free_count),
        .peak_count     (peak_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // start stays high from one transaction to the next unless a gap is taken
    task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [HANDLE_W-1:0] h,
                            input logic [SPRITE_W-1:0] sid, input logic [POS_W-1:0] x,
                            input logic [POS_W-1:0] y);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_mode      <= mode;
        i_handle    <= h;
        i_sprite_id <= sid;
        i_pos_x     <= x;
        i_pos_y     <= y;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic random_place();
        send_cmd(MODE_PLACE, HANDLE_W'($urandom), SPRITE_W'($urandom),
                 POS_W'($urandom), POS_W'($urandom));
    endtask

    // a slot in use, searched from a random start in the checker's registered map of used slots
    function automatic logic [HANDLE_W-1:0] pick_live();
        int base;
        base = $urandom_range(63);
        for (int i = 0; i < 64; i++) begin
            if (live_map[(base + i) % 64]) return HANDLE_W'((base + i) % 64);
        end
        return HANDLE_W'(base);
    endfunction

    task automatic random_step();
        int pick;
        pick = $urandom_range(99);
        if (pick < 1) begin
            // fill the table and run into the full case
            repeat (66) random_place();
        end else if (pick < 2) begin
            repeat ($urandom_range(64, 40))
                send_cmd(MODE_DESTROY, pick_live(), SPRITE_W'($urandom),
                         POS_W'($urandom), POS_W'($urandom));
        end else if (pick < 27) begin
            random_place();
        end else if (pick < 88) begin
            send_cmd(MODE_W'($urandom_range(MODE_DESTROY, MODE_UP)), pick_live(),
                     SPRITE_W'($urandom), POS_W'($urandom), POS_W'($urandom));
        end else begin
            send_cmd(MODE_W'($urandom), HANDLE_W'($urandom), SPRITE_W'($urandom),
                     POS_W'($urandom), POS_W'($urandom));
        end
    endtask

    initial begin
        int phase_idle [3];
        phase_idle = '{9, 64, 0};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: free handles and undefined modes
        send_cmd(MODE_DESTROY, 6'd0, 8'd0, 16'h0000, 16'h0000);
        send_cmd(MODE_UP, 6'd63, 8'd0, 16'h0000, 16'h0000);
        send_cmd(MODE_SPARE_A, 6'd21, 8'd0, 16'h0000, 16'h0000);
        send_cmd(MODE_SPARE_B, 6'd42, 8'hFF, 16'hFFFF, 16'hFFFF);
        // four placements, bottom to top 0 1 2 3, coordinate extremes
        send_cmd(MODE_PLACE, 6'd63, 8'd0, 16'h8000, 16'h7FFF);
        send_cmd(MODE_PLACE, 6'd0, 8'hFF, 16'h7FFF, 16'h8000);
        send_cmd(MODE_PLACE, 6'd5, 8'hFF, 16'hFFFF, 16'h0000);
        send_cmd(MODE_PLACE, 6'd42, 8'h5A, 16'h5555, 16'hAAAA);
        // already at the end: nothing moves
        send_cmd(MODE_UP, 6'd3, 8'd0, 16'h0000, 16'h0000);
        send_cmd(MODE_DOWN, 6'd0, 8'd0, 16'h0000, 16'h0000);
        send_cmd(MODE_TOP, 6'd3, 8'd0, 16'h0000, 16'h0000);
        send_cmd(MODE_BOTTOM, 6'd0, 8'd0, 16'h0000, 16'h0000);
        // reordering in the middle and at both ends
        send_cmd(MODE_UP, 6'd1, 8'd0, 16'h0000, 16'h0000);
        send_cmd(MODE_DOWN, 6'd2, 8'd0, 16'h0000, 16'h0000);
        send_cmd(MODE_TOP, 6'd0, 8'd0, 16'h0000, 16'h0000);
        send_cmd(MODE_BOTTOM, 6'd3, 8'd0, 16'h0000, 16'h0000);
        send_cmd(MODE_DOWN, 6'd0, 8'd0, 16'h0000, 16'h0000);
        send_cmd(MODE_UP, 6'd3, 8'd0, 16'h0000, 16'h0000);
        // destroy, reuse of the lowest free slot, then empty the stack
        send_cmd(MODE_DESTROY, 6'd1, 8'd0, 16'h0000, 16'h0000);
        send_cmd(MODE_TOP, 6'd1, 8'd0, 16'h0000, 16'h0000);
        send_cmd(MODE_PLACE, 6'd0, 8'h81, 16'h0001, 16'hFFFE);
        send_cmd(MODE_DESTROY, 6'd0, 8'd0, 16'h0000, 16'h0000);
        send_cmd(MODE_DESTROY, 6'd3, 8'd0, 16'h0000, 16'h0000);
        send_cmd(MODE_DESTROY, 6'd2, 8'd0, 16'h0000, 16'h0000);
        send_cmd(MODE_DESTROY, 6'd1, 8'd0, 16'h0000, 16'h0000);
        send_cmd(MODE_DOWN, 6'd1, 8'd0, 16'h0000, 16'h0000);

        for (int p = 0; p < 3; p++) begin
            idle_pct = phase_idle[p];
            while (n_sent < DIRECTED_CMDS + (p + 1) * TARGET_CMDS / 3) random_step();
        end
        start <= 1'b0;

        @(posedge i_clk);
        for (int w = 0; w < DRAIN_LIMIT && pending != 0; w++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (pending != 0) $error("%0d expected results never arrived", pending);
        $display("covered %0d commands: %0d ok, %0d table full, %0d handle not in use",
                 n_sent, ok_count, full_count, free_count);
        $display("stack depth reached %0d of 64 slots over three pacing phases", peak_count);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
